// ===== rtl/radix_integer_to_digits_core_macros.svh =====
// Assertion macros for the radix integer to digits core.
// Included by the top level; depends on nothing else.
`ifndef RADIX_INTEGER_TO_DIGITS_CORE_MACROS_SVH
`define RADIX_INTEGER_TO_DIGITS_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RITD_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("ritd same-cycle check failed");

// Next-cycle implication, checked outside reset
`define RITD_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("ritd next-cycle check failed");

`endif

// ===== rtl/ritd_pkg.sv =====
// Shared constants, types and helpers for the radix integer to digits core.
// No dependencies; imported by every module of the block.
package ritd_pkg;

    // Value width and derived sizes
    localparam int VALUE_BITS = 31;
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int RADIX_W    = 6;
    localparam int PROD_W     = VALUE_BITS + RADIX_W;
    localparam int CNT_W      = 6;

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // ASCII mapping
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] ALPHA_GAP = 8'd7;
    localparam logic [CNT_W-1:0] DEC_LIMIT = 6'd10;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DIGIT  = 3'b100
    } ritd_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // take a new item
        logic grow;   // step to the next higher power
        logic sub;    // take one power off the remainder
        logic emit;   // send current digit, move one place down
    } ritd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic value_zero;  // input value is zero
        logic can_grow;    // next power still fits in the value
        logic rem_ge;      // remainder holds at least one more power
        logic idx_zero;    // current place is the units place
    } ritd_status_t;

    // Digit value to ASCII character
    function automatic logic [7:0] digit_to_char(input logic [CNT_W-1:0] d);
        logic [7:0] c;
        c = CHAR_ZERO + 8'(d);
        if (d >= DEC_LIMIT)
        begin
            c = c + ALPHA_GAP;
        end
        return c;
    endfunction

endpackage

// ===== rtl/ritd_ctrl.sv =====
// Sequencing state machine of the radix integer to digits core.
// Depends on ritd_pkg; drives the datapath through ritd_cmd_t.
module ritd_ctrl
    import ritd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  ritd_status_t status,
    output ritd_cmd_t    cmd,
    output logic         busy
);

    ritd_state_t state_reg;
    ritd_state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (!status.value_zero)
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (status.can_grow)
                begin
                    cmd.grow = 1'b1;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.rem_ge)
                begin
                    cmd.sub = 1'b1;
                end
                else
                begin
                    cmd.emit = 1'b1;
                    if (status.idx_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/ritd_dpath.sv =====
// Datapath of the radix integer to digits core: radix register, power
// table, remainder and digit counters, result registers. Depends on ritd_pkg.
module ritd_dpath
    import ritd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  radix_we,
    input  logic [RADIX_W-1:0]    radix_wdata,
    input  ritd_cmd_t             cmd,
    output ritd_status_t          status,
    output logic                  result_valid,
    output logic [7:0]            digit_char,
    output logic                  last_digit,
    output logic                  empty_res
);

    logic [RADIX_W-1:0]    radix_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] pwr_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  result_valid_reg;
    logic [7:0]            digit_char_reg;
    logic                  last_digit_reg;
    logic                  empty_res_reg;
    logic [PROD_W-1:0]     prod;

    // Powers of the radix, entry k holds radix**k
    logic [VALUE_BITS-1:0] power_mem [VALUE_BITS];

    // Candidate next power
    assign prod = PROD_W'(pwr_reg) * PROD_W'(radix_reg);

    // Status to the controller
    assign status.value_zero = (value == '0);
    assign status.can_grow   = (prod <= PROD_W'(rem_reg));
    assign status.rem_ge     = (rem_reg >= pwr_reg);
    assign status.idx_zero   = (idx_reg == '0);

    // Radix register, clamped on write; result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg        <= RADIX_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (radix_we)
            begin
                if (radix_wdata < RADIX_MIN)
                begin
                    radix_reg <= RADIX_MIN;
                end
                else if (radix_wdata > RADIX_MAX)
                begin
                    radix_reg <= RADIX_MAX;
                end
                else
                begin
                    radix_reg <= radix_wdata;
                end
            end
            result_valid_reg <= (cmd.load && status.value_zero) || cmd.emit;
        end
    end

    // Power table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            power_mem[0] <= VALUE_BITS'(1);
        end
        else if (cmd.grow)
        begin
            power_mem[IDX_W'(idx_reg + 1'b1)] <= prod[VALUE_BITS-1:0];
        end
        if (cmd.emit)
        begin
            // no lower place after the units digit
            if (!status.idx_zero)
            begin
                pwr_reg <= power_mem[IDX_W'(idx_reg - 1'b1)];
            end
        end
        else if (cmd.load)
        begin
            pwr_reg <= VALUE_BITS'(1);
        end
        else if (cmd.grow)
        begin
            pwr_reg <= prod[VALUE_BITS-1:0];
        end
    end

    // Remainder, place index and digit counter
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= value;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.grow)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        else if (cmd.sub)
        begin
            rem_reg <= rem_reg - pwr_reg;
            cnt_reg <= cnt_reg + 1'b1;
        end
        else if (cmd.emit)
        begin
            idx_reg <= idx_reg - 1'b1;
            cnt_reg <= '0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load && status.value_zero)
        begin
            digit_char_reg <= '0;
            last_digit_reg <= 1'b1;
            empty_res_reg  <= 1'b1;
        end
        else if (cmd.emit)
        begin
            digit_char_reg <= digit_to_char(cnt_reg);
            last_digit_reg <= status.idx_zero;
            empty_res_reg  <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign digit_char   = digit_char_reg;
    assign last_digit   = last_digit_reg;
    assign empty_res    = empty_res_reg;

endmodule

// ===== rtl/radix_integer_to_digits_core.sv =====
// Top level of the radix integer to digits core.
// Depends on ritd_pkg, ritd_ctrl, ritd_dpath and the core macros header.
//
// Usage:
//   Write radix_wdata with radix_we high to set the base (2..36, values
//   outside clamp to the nearest limit); reset leaves base 10. Write it only
//   while busy is low and no digits are pending.
//   An item is taken at a clock edge with start high and busy low. Its
//   digits come out most significant first, one per result_valid pulse of
//   one cycle, with last_digit on the final one. A zero value gives a single
//   pulse with empty_res and last_digit set and digit_char zero.
//   Timing: a zero value is answered in the next cycle and busy stays low.
//   Otherwise busy stays high while the top place is found, stepping up
//   through the powers with the radix multiplier, then while each digit is
//   counted by subtract-and-compare, one subtraction per unit, and then sent.
//   Each digit appears the cycle after it is sent.
//   The receiver cannot stall; results must be taken as they appear.
//   Reset clears the state machine and strobe and sets base 10.
`include "radix_integer_to_digits_core_macros.svh"

module radix_integer_to_digits_core
    import ritd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  radix_we,
    input  logic [RADIX_W-1:0]    radix_wdata,
    output logic                  result_valid,
    output logic [7:0]            digit_char,
    output logic                  last_digit,
    output logic                  empty_res
);

    ritd_cmd_t    cmd;
    ritd_status_t status;
    logic         item_accept;
    logic         empty_out;

    // Sequencer
    ritd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Arithmetic and result registers
    ritd_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .radix_we     (radix_we),
        .radix_wdata  (radix_wdata),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .digit_char   (digit_char),
        .last_digit   (last_digit),
        .empty_res    (empty_res)
    );

    // Check terms
    assign item_accept = start && !busy;
    assign empty_out   = result_valid && empty_res;

    // Checks
    `RITD_ASSERT_NOW(a_empty_is_last, clk, rst_n, empty_out, last_digit && (digit_char == '0))
    `RITD_ASSERT_NEXT(a_zero_answers, clk, rst_n, item_accept && (value == '0), empty_out && !busy)
    `RITD_ASSERT_NEXT(a_nonzero_busy, clk, rst_n, item_accept && (value != '0), busy)
    `RITD_ASSERT_NOW(a_more_digits_busy, clk, rst_n, result_valid && !last_digit, busy)

endmodule
